@@ sv/u8u2_pkg.sv @@
// Package for the UTF-8 to UCS-2 decoder.
// Holds the lead-byte thresholds, field masks and the decode-step result type.
// No dependencies.
package u8u2_pkg;

  localparam int unsigned UNIT_W = 16;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned PEND_W = 2;

  // Lead-byte thresholds.
  localparam logic [BYTE_W-1:0] LEAD4_MIN = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD3_MIN = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD2_MIN = 8'hC0;

  // Payload masks for lead and continuation bytes.
  localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'h07;
  localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'h0F;
  localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'h1F;
  localparam logic [BYTE_W-1:0] CONT_MASK  = 8'h3F;

  // Continuation counts opened by each kind of lead byte.
  localparam logic [PEND_W-1:0] PEND_NONE  = 2'd0;
  localparam logic [PEND_W-1:0] PEND_ONE   = 2'd1;
  localparam logic [PEND_W-1:0] PEND_TWO   = 2'd2;
  localparam logic [PEND_W-1:0] PEND_THREE = 2'd3;

  // Outcome of one decode step.
  typedef struct packed {
    logic              emit;
    logic [UNIT_W-1:0] unit;
    logic              last;
    logic [PEND_W-1:0] pending;
    logic [UNIT_W-1:0] partial;
  } step_t;

endpackage

@@ sv/utf8_to_ucs2_decoder_unit.sv @@
// Top level of the UTF-8 to UCS-2 decoder.
// Instantiates u8u2_step; depends on u8u2_pkg.
//
// The decoder takes one UTF-8 byte per item and returns 16-bit code units.
// Lead bytes at or above 0xC0, 0xE0 and 0xF0 open sequences of one, two or
// three continuation bytes; each continuation adds six bits and the value is
// truncated to 16 bits, so four-byte sequences wrap. Bytes outside a sequence
// pass through unchanged, and nothing is validated. A string that ends in
// the middle of a sequence yields its unit at once with the missing bits
// zero, and last_unit marks the final unit of every string. The block takes
// one byte per cycle as long as the result side keeps up: a byte is captured
// in an input register, decoded by the step logic against the sequence
// state, and its unit, if any, lands in the output register from which it
// drives the outputs. The output register is what sets the rate: bytes
// that open or continue a sequence without ending it move on even while a
// unit waits to be taken, and only a byte that makes a unit is held back
// by a stall on the output side.
module utf8_to_ucs2_decoder_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        byte_valid,
  output logic                        byte_stall,
  input  logic [u8u2_pkg::BYTE_W-1:0] byte_in,
  input  logic                        end_of_string,
  output logic                        unit_valid,
  input  logic                        unit_stall,
  output logic [u8u2_pkg::UNIT_W-1:0] code_unit,
  output logic                        last_unit
);
  import u8u2_pkg::*;

  // Input register.
  logic              s1_valid;
  logic [BYTE_W-1:0] s1_byte;
  logic              s1_eos;

  // Sequence state.
  logic [PEND_W-1:0] pending;
  logic [UNIT_W-1:0] partial;

  step_t step;
  logic  out_free;
  logic  s1_fire;

  u8u2_step u_step (
    .pending       (pending),
    .partial       (partial),
    .byte_in       (s1_byte),
    .end_of_string (s1_eos),
    .step          (step)
  );

  // The output register can take a unit when it is empty or being drained.
  assign out_free   = !unit_valid || !unit_stall;
  // A byte leaves the input register when it makes no unit or the unit fits.
  assign s1_fire    = s1_valid && (!step.emit || out_free);
  assign byte_stall = s1_valid && !s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!byte_stall) begin
      s1_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      s1_byte <= byte_in;
      s1_eos  <= end_of_string;
    end
  end

  // Sequence state advances with every byte that leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= PEND_NONE;
      partial <= '0;
    end else if (s1_fire) begin
      pending <= step.pending;
      partial <= step.partial;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_valid <= 1'b0;
    end else if (s1_fire && step.emit) begin
      unit_valid <= 1'b1;
    end else if (!unit_stall) begin
      unit_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && step.emit) begin
      code_unit <= step.unit;
      last_unit <= step.last;
    end
  end

endmodule

@@ sv/u8u2_step.sv @@
// Decode logic for one byte of the UTF-8 to UCS-2 decoder.
// Pure combinational; depends on u8u2_pkg.
module u8u2_step (
  input  logic [u8u2_pkg::PEND_W-1:0] pending,
  input  logic [u8u2_pkg::UNIT_W-1:0] partial,
  input  logic [u8u2_pkg::BYTE_W-1:0] byte_in,
  input  logic                        end_of_string,
  output u8u2_pkg::step_t             step
);
  import u8u2_pkg::*;

  logic [UNIT_W-1:0] grown;
  logic [PEND_W-1:0] pend_dec;

  assign grown    = {partial[UNIT_W-7:0], byte_in[5:0] & CONT_MASK[5:0]};
  assign pend_dec = pending - PEND_ONE;

  always_comb begin
    step.emit    = 1'b0;
    step.unit    = '0;
    step.last    = end_of_string;
    step.pending = pending;
    step.partial = partial;

    if (pending == PEND_NONE) begin
      if (byte_in >= LEAD4_MIN) begin
        step.partial = {8'h00, byte_in & LEAD4_MASK};
        step.pending = PEND_THREE;
      end else if (byte_in >= LEAD3_MIN) begin
        step.partial = {8'h00, byte_in & LEAD3_MASK};
        step.pending = PEND_TWO;
      end else if (byte_in >= LEAD2_MIN) begin
        step.partial = {8'h00, byte_in & LEAD2_MASK};
        step.pending = PEND_ONE;
      end else begin
        step.emit = 1'b1;
        step.unit = {8'h00, byte_in};
      end
    end else begin
      step.partial = grown;
      step.pending = pend_dec;
      if (pend_dec == PEND_NONE) begin
        step.emit    = 1'b1;
        step.unit    = grown;
        step.partial = '0;
      end
    end

    // A string that ends inside a sequence is flushed with zero groups.
    if (!step.emit && end_of_string) begin
      step.emit = 1'b1;
      unique case (step.pending)
        PEND_ONE: step.unit = {step.partial[UNIT_W-7:0], 6'd0};
        PEND_TWO: step.unit = {step.partial[UNIT_W-13:0], 12'd0};
        default:  step.unit = '0;
      endcase
      step.pending = PEND_NONE;
      step.partial = '0;
    end
  end

endmodule

@@ sv/u8u2_checker.sv @@
// Port-level checks for the UTF-8 to UCS-2 decoder, bound to the top level.
// Depends on u8u2_pkg and utf8_to_ucs2_decoder_unit.
module u8u2_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        byte_valid,
  input logic                        byte_stall,
  input logic [u8u2_pkg::BYTE_W-1:0] byte_in,
  input logic                        end_of_string,
  input logic                        unit_valid,
  input logic                        unit_stall,
  input logic [u8u2_pkg::UNIT_W-1:0] code_unit,
  input logic                        last_unit
);
  import u8u2_pkg::*;

  // Strings whose last byte is in but whose last unit is not yet out.
  logic [1:0] open_ends;
  logic       byte_take;
  logic       unit_take;

  assign byte_take = byte_valid && !byte_stall;
  assign unit_take = unit_valid && !unit_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      open_ends <= 2'd0;
    end else begin
      open_ends <= open_ends + {1'b0, byte_take && end_of_string}
                 - {1'b0, unit_take && last_unit};
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !unit_valid)
    else $error("unit_valid set right after reset");

  a_unit_hold: assert property (@(posedge clk) disable iff (rst)
    unit_valid && unit_stall |=> unit_valid && $stable(code_unit) && $stable(last_unit))
    else $error("stalled unit changed");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    byte_stall |-> unit_valid)
    else $error("input stalled while output register is empty");

  a_last_owed: assert property (@(posedge clk) disable iff (rst)
    unit_take && last_unit |-> open_ends != 2'd0)
    else $error("last unit without a string end");

  a_ends_bound: assert property (@(posedge clk) disable iff (rst)
    open_ends != 2'd3)
    else $error("too many string ends in flight");

  // Byte value is watched only through the handshake.
  logic unused_byte;
  assign unused_byte = ^byte_in;

endmodule

bind utf8_to_ucs2_decoder_unit u8u2_checker u_u8u2_checker (
  .clk           (clk),
  .rst           (rst),
  .byte_valid    (byte_valid),
  .byte_stall    (byte_stall),
  .byte_in       (byte_in),
  .end_of_string (end_of_string),
  .unit_valid    (unit_valid),
  .unit_stall    (unit_stall),
  .code_unit     (code_unit),
  .last_unit     (last_unit)
);
